[rtl/core/utf8_byte_stream_decoder_defines.svh]
// assertion macros used by the checker of the decoder
`ifndef UTF8_BYTE_STREAM_DECODER_DEFINES_SVH
`define UTF8_BYTE_STREAM_DECODER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define UTF8BD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define UTF8BD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/utf8bd_pkg.sv]
package utf8bd_pkg;

	localparam int CP_W = 21;
	localparam logic [CP_W-1:0] REPL_CP = 21'h00FFFD;
	localparam logic [CP_W-1:0] MIN_3B = 21'h000800;
	localparam logic [CP_W-1:0] MIN_4B = 21'h010000;
	localparam logic [CP_W-1:0] MAX_CP = 21'h10FFFF;

	localparam logic [7:0] LEAD_ASCII_END = 8'h80;
	localparam logic [7:0] LEAD_2B = 8'hC2;
	localparam logic [7:0] LEAD_3B = 8'hE0;
	localparam logic [7:0] LEAD_4B = 8'hF0;
	localparam logic [7:0] LEAD_BAD = 8'hF5;
	localparam logic [7:0] CONT_MASK = 8'hC0;
	localparam logic [7:0] CONT_TAG = 8'h80;

	// results caused by one input item: some replacements, then maybe one tail
	typedef struct packed {
		logic [2:0]      nrep;
		logic            tail_vld;
		logic [CP_W-1:0] tail_cp;
		logic            tail_rep;
	} burst_t;

endpackage

[rtl/core/utf8bd_decode.sv]
module utf8bd_decode (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  logic [7:0]          data_byte,
	input  logic                stream_end,
	output utf8bd_pkg::burst_t  burst
);
	import utf8bd_pkg::*;

	logic [1:0]      exp_q;
	logic [1:0]      taken_q;
	logic [CP_W-1:0] pv_q;
	logic [1:0]      exp_d;
	logic [1:0]      taken_d;
	logic [CP_W-1:0] pv_d;

	logic [1:0]      lead_exp;
	logic [CP_W-1:0] lead_pv;
	logic            lead_tail_vld;
	logic [CP_W-1:0] lead_tail_cp;
	logic            lead_tail_rep;

	logic            is_cont;
	logic [CP_W-1:0] pv_shift;
	logic [1:0]      taken_inc;
	logic            bad_seq;

	// what the byte does when seen as a lead
	always_comb begin
		lead_exp = 2'd0;
		lead_pv = '0;
		lead_tail_vld = 1'b1;
		lead_tail_cp = REPL_CP;
		lead_tail_rep = 1'b1;
		if (data_byte < LEAD_ASCII_END) begin
			lead_tail_cp = {{(CP_W-8){1'b0}}, data_byte};
			lead_tail_rep = 1'b0;
		end else if (data_byte < LEAD_2B) begin
			lead_tail_vld = 1'b1;
		end else if (data_byte < LEAD_3B) begin
			lead_exp = 2'd1;
			lead_pv = {{(CP_W-5){1'b0}}, data_byte[4:0]};
			lead_tail_vld = 1'b0;
		end else if (data_byte < LEAD_4B) begin
			lead_exp = 2'd2;
			lead_pv = {{(CP_W-4){1'b0}}, data_byte[3:0]};
			lead_tail_vld = 1'b0;
		end else if (data_byte < LEAD_BAD) begin
			lead_exp = 2'd3;
			lead_pv = {{(CP_W-3){1'b0}}, data_byte[2:0]};
			lead_tail_vld = 1'b0;
		end
	end

	assign is_cont = (data_byte & CONT_MASK) == CONT_TAG;
	assign pv_shift = {pv_q[CP_W-7:0], data_byte[5:0]};
	assign taken_inc = taken_q + 2'd1;
	assign bad_seq = ((exp_q == 2'd2) && (pv_shift < MIN_3B)) ||
		((exp_q == 2'd3) && ((pv_shift < MIN_4B) || (pv_shift > MAX_CP)));

	always_comb begin
		exp_d = exp_q;
		taken_d = taken_q;
		pv_d = pv_q;
		burst = '0;
		if (stream_end) begin
			exp_d = 2'd0;
			taken_d = 2'd0;
			pv_d = '0;
		end else if (exp_q == 2'd0) begin
			exp_d = lead_exp;
			taken_d = 2'd0;
			pv_d = lead_pv;
			burst.tail_vld = lead_tail_vld;
			burst.tail_cp = lead_tail_cp;
			burst.tail_rep = lead_tail_rep;
		end else if (is_cont) begin
			if (taken_inc == exp_q) begin
				exp_d = 2'd0;
				taken_d = 2'd0;
				pv_d = '0;
				if (bad_seq) begin
					burst.nrep = {1'b0, exp_q} + 3'd1;
				end else begin
					burst.tail_vld = 1'b1;
					burst.tail_cp = pv_shift;
					burst.tail_rep = 1'b0;
				end
			end else begin
				taken_d = taken_inc;
				pv_d = pv_shift;
			end
		end else begin
			// broken sequence: one replacement per byte so far, then start over
			burst.nrep = {1'b0, taken_q} + 3'd1;
			exp_d = lead_exp;
			taken_d = 2'd0;
			pv_d = lead_pv;
			burst.tail_vld = lead_tail_vld;
			burst.tail_cp = lead_tail_cp;
			burst.tail_rep = lead_tail_rep;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q <= 2'd0;
			taken_q <= 2'd0;
			pv_q <= '0;
		end else if (take) begin
			exp_q <= exp_d;
			taken_q <= taken_d;
			pv_q <= pv_d;
		end
	end

endmodule

[rtl/core/utf8bd_emit.sv]
module utf8bd_emit (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     load,
	input  utf8bd_pkg::burst_t       burst,
	output logic                     room,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [utf8bd_pkg::CP_W-1:0] out_cp,
	output logic                     out_rep,
	output logic                     out_last
);
	import utf8bd_pkg::*;

	logic       s1_valid_s1;
	burst_t     s1_burst_s1;
	logic       em_valid_q;
	logic [2:0] em_nrep_q;
	logic       em_tail_vld_q;
	logic [CP_W-1:0] em_cp_q;
	logic       em_rep_q;
	logic       em_done;
	logic       em_free;
	logic       s1_move;
	logic       s1_load;

	assign out_valid = em_valid_q;
	assign out_cp = (em_nrep_q != 3'd0) ? REPL_CP : em_cp_q;
	assign out_rep = (em_nrep_q != 3'd0) ? 1'b1 : em_rep_q;
	assign out_last = (em_nrep_q == 3'd0) || ((em_nrep_q == 3'd1) && !em_tail_vld_q);

	assign em_done = em_valid_q && out_ready && out_last;
	assign em_free = !em_valid_q || em_done;
	assign s1_move = s1_valid_s1 && em_free;
	assign room = !s1_valid_s1 || em_free;
	// items that cause no result never enter the buffer
	assign s1_load = load && ((burst.nrep != 3'd0) || burst.tail_vld);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (s1_load) begin
			s1_valid_s1 <= 1'b1;
		end else if (s1_move) begin
			s1_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_load) begin
			s1_burst_s1 <= burst;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			em_valid_q <= 1'b0;
			em_nrep_q <= 3'd0;
			em_tail_vld_q <= 1'b0;
		end else if (s1_move) begin
			em_valid_q <= 1'b1;
			em_nrep_q <= s1_burst_s1.nrep;
			em_tail_vld_q <= s1_burst_s1.tail_vld;
		end else if (em_done) begin
			em_valid_q <= 1'b0;
		end else if (em_valid_q && out_ready) begin
			em_nrep_q <= em_nrep_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			em_cp_q <= s1_burst_s1.tail_cp;
			em_rep_q <= s1_burst_s1.tail_rep;
		end
	end

endmodule

[rtl/core/utf8_byte_stream_decoder.sv]
// UTF-8 decoder: takes one byte per item and gives Unicode code points, one per output item,
// with U+FFFD marked in m_tuser for malformed bytes. An input item is taken every cycle
// while output is flowing; an item that causes k results keeps the output register busy
// until all k are taken, so the sustained rate is one byte per cycle for well-formed text
// and slows only on errors (up to four results for one byte). The byte is decoded into
// a one-entry result buffer, then replayed by the output register, which lets the next
// byte enter while a result waits for m_tready. s_tlast marks end of stream: its data is
// ignored and an unfinished sequence is dropped.
module utf8_byte_stream_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] data_byte
	input  logic        s_tlast,  // stream_end
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // [20:0] code_point, [23:21] zero
	output logic        m_tuser,  // is_replacement
	output logic        m_tlast   // last_of_run
);
	import utf8bd_pkg::*;

	logic            take;
	burst_t          burst;
	logic [CP_W-1:0] cp;

	assign take = s_tvalid && s_tready;

	utf8bd_decode u_decode (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.data_byte  (s_tdata),
		.stream_end (s_tlast),
		.burst      (burst)
	);

	utf8bd_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (take),
		.burst     (burst),
		.room      (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_cp    (cp),
		.out_rep   (m_tuser),
		.out_last  (m_tlast)
	);

	assign m_tdata = {3'b000, cp};

endmodule

[rtl/core/utf8bd_checker.sv]
`include "utf8_byte_stream_decoder_defines.svh"

module utf8bd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic        m_tuser,
	input logic        m_tlast
);

	logic        stall;
	logic [25:0] m_item;
	logic [20:0] cp;
	logic [2:0]  pad;

	assign stall = m_tvalid && !m_tready;
	assign m_item = {m_tdata, m_tuser, m_tlast};
	assign cp = m_tdata[20:0];
	assign pad = m_tdata[23:21];

	// a stalled result holds its value
	`UTF8BD_ASSERT_NEXT(a_hold, stall, m_tvalid && $stable(m_item), "stalled result changed")

	// a replacement always carries U+FFFD
	`UTF8BD_ASSERT_NOW(a_repl_cp, m_tvalid && m_tuser, cp == 21'h00FFFD, "replacement is not U+FFFD")

	// only code points in range, padding stays zero
	`UTF8BD_ASSERT_NOW(a_range, m_tvalid, (cp <= 21'h10FFFF) && (pad == 3'b000), "code point out of range")

	// only the final result of an item may be a real code point
	`UTF8BD_ASSERT_NOW(a_prefix_repl, m_tvalid && !m_tlast, m_tuser, "non-final result is not a replacement")

	// input is held off only while a result waits
	`UTF8BD_ASSERT_NOW(a_stall_cause, !s_tready, m_tvalid, "input stalled with no result pending")

endmodule

bind utf8_byte_stream_decoder utf8bd_checker u_utf8bd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

[dv/tb.sv]
`timescale 1ns / 1ps

module tb;
	import utf8bd_pkg::*;

	localparam int CYCLE_LIMIT = 300000;
	localparam int RANDOM_ITEMS = 403;
	localparam int HOLD_AT = 150;
	localparam int HOLD_CYCLES = 300;

	typedef struct packed {
		logic [CP_W-1:0] cp;
		logic            rep;
		logic            last;
	} decoded_t;

	typedef struct {
		logic [7:0] b;
		logic       eos;
		int         gap_after;
		bit         drain;
	} byte_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;   // [7:0] data_byte
	logic        s_tlast = 1'b0; // stream_end
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;        // [20:0] code_point, [23:21] zero
	logic        m_tuser;        // is_replacement
	logic        m_tlast;        // last_of_run

	utf8_byte_stream_decoder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	byte_item_t byte_queue[$];
	decoded_t   expected_cps[$];
	decoded_t   item_cps[$];
	decoded_t   got_cp;
	byte_item_t nxt_byte;

	// decoder state mirrored on the testbench side
	logic [1:0]      cont_need = '0;
	logic [1:0]      cont_got = '0;
	logic [CP_W-1:0] cp_acc = '0;

	int  mismatches = 0;
	int  total_items = 0;
	int  taken_cnt = 0;
	int  cycle = 0;
	int  tx_gap = 0;
	int  rx_gap = 0;
	int  hold_left = 0;
	bit  hold_done = 1'b0;
	bit  rx_hold = 1'b0;
	bit  offering;
	bit  calm = 1'b0;
	bit  drain_next = 1'b0;

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic push_cp(input logic [CP_W-1:0] cp, input logic rep);
		decoded_t r;
		r.cp = cp;
		r.rep = rep;
		r.last = 1'b0;
		item_cps.push_back(r);
	endtask

	task automatic clear_seq();
		cont_need = '0;
		cont_got = '0;
		cp_acc = '0;
	endtask

	task automatic start_lead(input logic [7:0] b);
		if (b < LEAD_ASCII_END)
			push_cp({13'd0, b}, 1'b0);
		else if (b < LEAD_2B)
			push_cp(REPL_CP, 1'b1);
		else if (b < LEAD_3B) begin
			cont_need = 2'd1;
			cont_got = '0;
			cp_acc = {16'd0, b[4:0]};
		end else if (b < LEAD_4B) begin
			cont_need = 2'd2;
			cont_got = '0;
			cp_acc = {17'd0, b[3:0]};
		end else if (b < LEAD_BAD) begin
			cont_need = 2'd3;
			cont_got = '0;
			cp_acc = {18'd0, b[2:0]};
		end else
			push_cp(REPL_CP, 1'b1);
	endtask

	// works out the code points one accepted byte gives and queues them
	task automatic decode_byte(input logic [7:0] b, input logic eos);
		bit       bad;
		decoded_t r;
		item_cps.delete();
		if (eos)
			clear_seq();
		else if (cont_need == 0)
			start_lead(b);
		else if ((b & CONT_MASK) == CONT_TAG) begin
			cp_acc = {cp_acc[CP_W-7:0], b[5:0]};
			cont_got = cont_got + 2'd1;
			if (cont_got >= cont_need) begin
				bad = (cont_need == 2 && cp_acc < MIN_3B) ||
					(cont_need == 3 && (cp_acc < MIN_4B || cp_acc > MAX_CP));
				if (bad) begin
					for (int k = 0; k <= cont_need; k++)
						push_cp(REPL_CP, 1'b1);
				end else
					push_cp(cp_acc, 1'b0);
				clear_seq();
			end
		end else begin
			// broken sequence: one replacement for the lead and each continuation so far
			for (int k = 0; k <= cont_got; k++)
				push_cp(REPL_CP, 1'b1);
			clear_seq();
			start_lead(b);
		end
		foreach (item_cps[k]) begin
			r = item_cps[k];
			r.last = (k == item_cps.size() - 1);
			expected_cps.push_back(r);
		end
	endtask

	task automatic queue_byte(input logic [7:0] b, input logic eos = 1'b0);
		byte_item_t it;
		it.b = b;
		it.eos = eos;
		it.gap_after = calm ? 0 : idle_len();
		it.drain = drain_next;
		drain_next = 1'b0;
		byte_queue.push_back(it);
	endtask

	function automatic logic [7:0] cont_byte();
		return {2'b10, 6'($urandom)};
	endfunction

	task automatic queue_sequence();
		int         r;
		int         n;
		logic [7:0] lead;
		r = $urandom_range(0, 99);
		if (r < 30)
			queue_byte(8'($urandom_range(0, 127)));
		else if (r < 50) begin
			queue_byte(8'($urandom_range(LEAD_2B, LEAD_3B - 1)));
			queue_byte(cont_byte());
		end else if (r < 68) begin
			queue_byte(8'($urandom_range(LEAD_3B, LEAD_4B - 1)));
			repeat (2) queue_byte(cont_byte());
		end else if (r < 82) begin
			queue_byte(8'($urandom_range(LEAD_4B, LEAD_BAD - 1)));
			repeat (3) queue_byte(cont_byte());
		end else if (r < 90)
			queue_byte(8'($urandom));
		else if (r < 96) begin
			// sequence cut short, the next item breaks it unless it is a continuation byte
			lead = 8'($urandom_range(LEAD_3B, LEAD_BAD - 1));
			n = (lead >= LEAD_4B) ? 3 : 2;
			queue_byte(lead);
			repeat ($urandom_range(0, n - 1)) queue_byte(cont_byte());
		end else begin
			if ($urandom_range(0, 1))
				queue_byte(8'($urandom_range(LEAD_2B, LEAD_BAD - 1)));
			queue_byte(8'($urandom), 1'b1);
		end
	endtask

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tlast <= 1'b0;
		end else begin
			offering = s_tvalid;
			if (s_tvalid && s_tready) begin
				decode_byte(s_tdata, s_tlast);
				taken_cnt <= taken_cnt + 1;
				offering = 1'b0;
			end
			if (!offering) begin
				if (tx_gap > 0)
					tx_gap--;
				else if (byte_queue.size() > 0 &&
						!(byte_queue[0].drain && expected_cps.size() > 0)) begin
					nxt_byte = byte_queue.pop_front();
					s_tdata <= nxt_byte.b;
					s_tlast <= nxt_byte.eos;
					tx_gap = nxt_byte.gap_after;
					offering = 1'b1;
				end
			end
			s_tvalid <= offering;
		end
	end

	// one long receiver stall while the sender keeps going
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
			rx_hold <= 1'b0;
		end else if (!hold_done && taken_cnt >= HOLD_AT) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
			rx_hold <= 1'b1;
		end else if (hold_left > 1)
			hold_left <= hold_left - 1;
		else begin
			hold_left <= 0;
			rx_hold <= 1'b0;
		end
	end

	// receiver and checker
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else begin
			if (m_tvalid && m_tready) begin
				if (expected_cps.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected item cp=%h rep=%b last=%b", $time,
							m_tdata[CP_W-1:0], m_tuser, m_tlast);
				end else begin
					got_cp = expected_cps.pop_front();
					if (m_tdata[CP_W-1:0] !== got_cp.cp || m_tuser !== got_cp.rep ||
							m_tlast !== got_cp.last) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: exp cp=%h rep=%b last=%b, got cp=%h rep=%b last=%b",
								$time, got_cp.cp, got_cp.rep, got_cp.last,
								m_tdata[CP_W-1:0], m_tuser, m_tlast);
					end
				end
				// some windows run with the receiver always ready
				rx_gap = (((cycle / 1500) % 3) == 1) ? 0 : idle_len();
			end
			if (rx_hold)
				m_tready <= 1'b0;
			else if (rx_gap > 0) begin
				m_tready <= 1'b0;
				rx_gap--;
			end else
				m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle > CYCLE_LIMIT) begin
			$display("tb failed");
			$finish;
		end
	end

	initial begin
		int dir_cnt;
		// single bytes: ascii extremes and bad leads
		queue_byte(8'h00);
		queue_byte(8'h7F);
		queue_byte(8'h80);
		queue_byte(8'hF5);
		queue_byte(8'hFF);
		queue_byte(8'hC1);
		// smallest two-byte value
		queue_byte(8'hC2);
		queue_byte(8'h80);
		// literal U+FFFD, not a replacement
		queue_byte(8'hEF);
		queue_byte(8'hBF);
		queue_byte(8'hBD);
		// overlong three-byte form
		queue_byte(8'hE0);
		queue_byte(8'h80);
		queue_byte(8'h80);
		// largest scalar value, then one past it
		queue_byte(8'hF4);
		queue_byte(8'h8F);
		queue_byte(8'hBF);
		queue_byte(8'hBF);
		queue_byte(8'hF4);
		queue_byte(8'h90);
		queue_byte(8'h80);
		queue_byte(8'h80);
		// missing continuation, offending byte taken as ascii
		queue_byte(8'hE2);
		queue_byte(8'h82);
		queue_byte(8'h41);
		// end of stream drops the open sequence
		queue_byte(8'hC3);
		queue_byte(8'hA9, 1'b1);
		dir_cnt = byte_queue.size();

		while (byte_queue.size() < dir_cnt + RANDOM_ITEMS) begin
			if ($urandom_range(0, 39) == 0)
				calm = !calm;
			if (!drain_next && byte_queue.size() >= dir_cnt + 250 &&
					byte_queue.size() < dir_cnt + 256)
				drain_next = 1'b1;
			queue_sequence();
		end
		total_items = byte_queue.size();

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (taken_cnt < total_items)
			@(posedge clk);
		while (expected_cps.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule

[utf8_byte_stream_decoder.f]
+incdir+rtl/core
rtl/core/utf8bd_pkg.sv
rtl/core/utf8bd_decode.sv
rtl/core/utf8bd_emit.sv
rtl/core/utf8_byte_stream_decoder.sv
rtl/core/utf8bd_checker.sv
dv/tb.sv
